@@ sv/tct_pkg.sv @@
// ---------------------------------------------------------------------------
// tct_pkg
// Shared types, codes and constants of the timed callback table.
// ---------------------------------------------------------------------------
package tct_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int TIME_W      = 48;
	localparam int CB_W        = 16;
	localparam int CTX_W       = 32;
	localparam int DELAY_W     = 32;
	localparam int AGE_W       = 16;
	localparam logic [TIME_W-1:0] DELAY_CLAMP = TIME_W'(2073600000);

	typedef enum logic [1:0] {
		FUNC_SCHED  = 2'd0,
		FUNC_REMOVE = 2'd1,
		FUNC_RUN    = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		KIND_STATUS = 2'd0,
		KIND_FIRED  = 2'd1,
		KIND_DELAY  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH,
		S_PICK,
		S_DECIDE,
		S_FIRE,
		S_DELAY
	} state_t;

	typedef struct packed {
		logic load;
		logic inc_idx;
		logic scan_rm;
		logic scan_pick;
		logic finish;
		logic fire;
		logic out_delay;
	} cmd_t;

	typedef struct packed {
		logic idx_last;
		logic found;
	} stat_t;

endpackage

@@ sv/tct_ctrl.sv @@
// ---------------------------------------------------------------------------
// tct_ctrl
// Sequencer: one table entry per cycle for removal scans and pick passes.
// ---------------------------------------------------------------------------
module tct_ctrl
	import tct_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  logic  [1:0] func,
	input  stat_t st,
	output cmd_t  cmd,
	output logic  busy
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					case (func_t'(func)) inside
						FUNC_SCHED, FUNC_REMOVE: state_d = S_SCAN;
						FUNC_RUN:                state_d = S_PICK;
						default:                 state_d = S_IDLE;
					endcase
				end
			end
			S_SCAN: begin
				cmd.scan_rm = 1'b1;
				cmd.inc_idx = 1'b1;
				if (st.idx_last) state_d = S_FINISH;
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			S_PICK: begin
				cmd.scan_pick = 1'b1;
				cmd.inc_idx   = 1'b1;
				if (st.idx_last) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				state_d = st.found ? S_FIRE : S_DELAY;
			end
			S_FIRE: begin
				cmd.fire = 1'b1;
				state_d  = S_PICK;
			end
			S_DELAY: begin
				cmd.out_delay = 1'b1;
				state_d       = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

@@ sv/tct_dp.sv @@
// ---------------------------------------------------------------------------
// tct_dp
// Entry table, scan index, pick and earliest trackers, result registers.
// ---------------------------------------------------------------------------
module tct_dp
	import tct_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	output stat_t                     st,
	input  logic [1:0]                func,
	input  logic [CB_W-1:0]           callback_id,
	input  logic [CTX_W-1:0]          context_id,
	input  logic signed [DELAY_W-1:0] interval_ms,
	input  logic [TIME_W-1:0]         now_ms,
	output logic                      valid,
	output logic [1:0]                kind,
	output logic [1:0]                status,
	output logic [CB_W-1:0]           fired_callback,
	output logic [CTX_W-1:0]          fired_context,
	output logic signed [DELAY_W-1:0] next_delay,
	output logic                      last
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic [ENTRIES-1:0] ev_q;
	logic [TIME_W-1:0]  due_q [ENTRIES];
	logic [CB_W-1:0]    ecb_q [ENTRIES];
	logic [CTX_W-1:0]   ectx_q[ENTRIES];
	logic [AGE_W-1:0]   age_q [ENTRIES];

	logic [IW-1:0]      idx_q, slot_q, pk_q;
	logic [CB_W-1:0]    cb_q;
	logic [CTX_W-1:0]   ctx_q;
	logic [TIME_W-1:0]  now_q, nd_q, early_q;
	logic [AGE_W-1:0]   pk_age_q;
	logic               ins_q, hit_q, slot_ok_q, pk_ok_q, any_q;

	logic [TIME_W:0]    sum;
	logic               m, v, is_due;
	logic [TIME_W-1:0]  diff, dly;

	assign sum    = {1'b0, now_ms} + {18'd0, interval_ms[DELAY_W-2:0]};
	assign v      = ev_q[idx_q];
	assign m      = v && (ecb_q[idx_q] == cb_q) && (ectx_q[idx_q] == ctx_q);
	assign is_due = now_q >= due_q[idx_q];
	assign diff   = early_q - now_q;
	assign dly    = !(early_q > now_q) ? '0 : (diff > DELAY_CLAMP ? DELAY_CLAMP : diff);

	assign st.idx_last = (idx_q == IW'(ENTRIES - 1));
	assign st.found    = pk_ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_q  <= '0;
			valid <= 1'b0;
			idx_q <= '0;
		end else begin
			valid <= 1'b0;
			if (cmd.inc_idx) idx_q <= idx_q + IW'(1);
			if (cmd.scan_rm && m) ev_q[idx_q] <= 1'b0;
			if (cmd.fire) begin
				ev_q[pk_q] <= 1'b0;
				idx_q      <= '0;
				valid      <= 1'b1;
			end
			if (cmd.load) idx_q <= '0;
			if (cmd.finish) begin
				if (ins_q && slot_ok_q) ev_q[slot_q] <= 1'b1;
				valid <= 1'b1;
			end
			if (cmd.out_delay) valid <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cb_q      <= callback_id;
			ctx_q     <= context_id;
			now_q     <= now_ms;
			ins_q     <= (func_t'(func) == FUNC_SCHED) && !interval_ms[DELAY_W-1];
			// saturate the due time at the top of the clock range
			nd_q      <= sum[TIME_W] ? '1 : sum[TIME_W-1:0];
			hit_q     <= 1'b0;
			slot_ok_q <= 1'b0;
			pk_ok_q   <= 1'b0;
			any_q     <= 1'b0;
		end
		if (cmd.scan_rm) begin
			if (m) hit_q <= 1'b1;
			if ((!v || m) && !slot_ok_q) begin
				slot_q    <= idx_q;
				slot_ok_q <= 1'b1;
			end
		end
		if (cmd.scan_pick && v) begin
			if (is_due && (!pk_ok_q || age_q[idx_q] < pk_age_q)) begin
				pk_q     <= idx_q;
				pk_age_q <= age_q[idx_q];
				pk_ok_q  <= 1'b1;
			end
			if (!any_q || due_q[idx_q] < early_q) begin
				early_q <= due_q[idx_q];
				any_q   <= 1'b1;
			end
		end
		if (cmd.finish) begin
			if (ins_q && slot_ok_q) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (ev_q[i]) age_q[i] <= age_q[i] + AGE_W'(1);
				end
				age_q[slot_q]  <= '0;
				due_q[slot_q]  <= nd_q;
				ecb_q[slot_q]  <= cb_q;
				ectx_q[slot_q] <= ctx_q;
			end
			kind           <= KIND_STATUS;
			status         <= ins_q ? (slot_ok_q ? ST_OK : ST_FULL)
			                        : (hit_q ? ST_OK : ST_NOTFOUND);
			fired_callback <= '0;
			fired_context  <= '0;
			next_delay     <= '0;
			last           <= 1'b1;
		end
		if (cmd.fire) begin
			pk_ok_q        <= 1'b0;
			any_q          <= 1'b0;
			kind           <= KIND_FIRED;
			status         <= ST_OK;
			fired_callback <= ecb_q[pk_q];
			fired_context  <= ectx_q[pk_q];
			next_delay     <= '0;
			last           <= 1'b0;
		end
		if (cmd.out_delay) begin
			kind           <= KIND_DELAY;
			status         <= ST_OK;
			fired_callback <= '0;
			fired_context  <= '0;
			next_delay     <= any_q ? DELAY_W'(dly) : '1;
			last           <= 1'b1;
		end
	end

endmodule

@@ sv/timed_callback_table.sv @@
// ---------------------------------------------------------------------------
// timed_callback_table
// Table of pending timed events with schedule, remove and run requests.
// ---------------------------------------------------------------------------
// schedule/remove: one scan of the table, then a status result
// run: (fired+1) passes over the table, one result per pass; each pass scans
// the table one entry per cycle
// one request at a time; busy is low again when the last result is shown
// results are strobed by valid for one cycle; the receiver cannot stall
// arst_n clears all entries at once; no clearing pass is needed
module timed_callback_table
	import tct_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                func,
	input  logic [CB_W-1:0]           callback_id,
	input  logic [CTX_W-1:0]          context_id,
	input  logic signed [DELAY_W-1:0] interval_ms,
	input  logic [TIME_W-1:0]         now_ms,
	output logic                      valid,
	output logic [1:0]                kind,
	output logic [1:0]                status,
	output logic [CB_W-1:0]           fired_callback,
	output logic [CTX_W-1:0]          fired_context,
	output logic signed [DELAY_W-1:0] next_delay,
	output logic                      last
);

	cmd_t  cmd;
	stat_t st;

	tct_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy)
	);

	tct_dp #(.ENTRIES(ENTRIES)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.func           (func),
		.callback_id    (callback_id),
		.context_id     (context_id),
		.interval_ms    (interval_ms),
		.now_ms         (now_ms),
		.valid          (valid),
		.kind           (kind),
		.status         (status),
		.fired_callback (fired_callback),
		.fired_context  (fired_context),
		.next_delay     (next_delay),
		.last           (last)
	);

`ifndef NO_ASSERTIONS
	a_fire_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && kind == KIND_FIRED) |-> !last)
		else $error("fired event marked last");
	a_delay_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && kind == KIND_DELAY) |-> last)
		else $error("delay result not last");
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && kind == KIND_STATUS) |-> last)
		else $error("status result not last");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && last) |-> !busy)
		else $error("busy after final result");
`endif

endmodule
